// ===== rtl/lcdws_pkg.sv =====
// Shared types, constants and the power-of-ten table for the character LCD
// write sequencer. No dependencies; every other file but lcdws_cmp_sub uses it by scoped names.
package lcdws_pkg;

    localparam int LINE_LENGTH_DEF = 16;

    localparam logic [2:0] KIND_CMD    = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_GOTO   = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;
    localparam logic [2:0] KIND_INIT   = 3'd5;

    localparam logic [7:0] ROW2_ADDR   = 8'h40;
    localparam logic [7:0] CMD_ROW2    = 8'hC0;
    localparam logic [7:0] CMD_SETADDR = 8'h80;
    localparam logic [7:0] CMD_FUNC8   = 8'h3C;
    localparam logic [7:0] CMD_DISPON  = 8'h0C;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] NIB_FUNC4   = 8'h02;
    localparam logic [7:0] NIB_LINES   = 8'h08;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;

    localparam logic [2:0] LAST_DIGIT  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        first_of_string;
        logic [7:0]  column;
        logic [7:0]  row;
    } t_in_item;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_value;
        logic       last;
    } t_out_item;

    // One byte handed from the sequencer to the transfer stage.
    typedef struct packed {
        logic       valid;
        logic       rs;
        logic [7:0] data;
        logic       split;
        logic       last;
    } t_byte_req;

    function automatic logic [15:0] pow10(input logic [2:0] idx);
        logic [15:0] p;
        unique case (idx)
            3'd0:    p = 16'd10000;
            3'd1:    p = 16'd1000;
            3'd2:    p = 16'd100;
            3'd3:    p = 16'd10;
            default: p = 16'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/lcdws_cmp_sub.sv =====
// Shared compare-and-subtract unit used for decimal digit extraction.
// Depends on nothing.
module lcdws_cmp_sub (
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic        o_ge,
    output logic [15:0] o_diff
);

    logic [16:0] diff_w;

    assign diff_w = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~diff_w[16];
    assign o_diff = diff_w[15:0];

endmodule

// ===== rtl/lcdws_xfer.sv =====
// Transfer stage: splits bytes into nibbles when asked and holds each bus
// transfer in an output register. Depends on lcdws_pkg.
module lcdws_xfer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcdws_pkg::t_byte_req i_req,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lcdws_pkg::t_out_item o_item
);

    logic                 r_full;
    logic                 r_hi;
    logic                 r_rs;
    logic [7:0]           r_data;
    logic                 r_split;
    logic                 r_last;
    logic                 r_ovalid;
    lcdws_pkg::t_out_item r_out;
    lcdws_pkg::t_out_item n_out;
    logic                 load_out;
    logic                 byte_done;

    assign o_ready  = ~r_full;
    assign load_out = r_full & (~r_ovalid | ~i_stall);

    always_comb begin
        n_out.reg_select = r_rs;
        if (r_split && r_hi) begin
            n_out.bus_value = {4'b0000, r_data[7:4]};
            n_out.last      = 1'b0;
            byte_done       = 1'b0;
        end else if (r_split) begin
            n_out.bus_value = {4'b0000, r_data[3:0]};
            n_out.last      = r_last;
            byte_done       = 1'b1;
        end else begin
            n_out.bus_value = r_data;
            n_out.last      = r_last;
            byte_done       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= 1'b0;
            r_hi     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_req.valid && !r_full) begin
                r_full <= 1'b1;
                r_hi   <= 1'b1;
            end else if (load_out) begin
                r_hi <= 1'b0;
                if (byte_done) begin
                    r_full <= 1'b0;
                end
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && !r_full) begin
            r_rs    <= i_req.rs;
            r_data  <= i_req.data;
            r_split <= i_req.split;
            r_last  <= i_req.last;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule

// ===== rtl/char_lcd_write_sequencer.sv =====
// Top level of the character LCD write sequencer: request sequencer with
// digit extraction on a shared compare-subtract unit, feeding the transfer
// stage. Depends on lcdws_pkg, lcdws_cmp_sub and lcdws_xfer.
//
// Usage: a request item is taken on the input channel when i_in_valid is
// high and o_in_stall is low; o_in_stall stays high until every byte of
// the current request has been handed to the transfer stage. Each result
// item is one enable-pulsed bus transfer, offered on o_out_valid and taken
// when i_out_stall is low; the final transfer of a request has last set.
// The user must write the mode bit through i_cfg_wr_en and i_cfg_wr_data
// only while idle; the block itself does not enforce this.
// The first transfer of a command, data, goto or init request passes through
// the sequencer state, the transfer stage's byte register and its output
// register; the transfer stage takes a new byte only once the last transfer
// of its current byte is loaded. A number request iterates on the shared
// compare-subtract unit, with at most 41 subtractions. Kinds six and seven
// are taken and produce nothing.
// Reset selects 4-bit mode, clears the string position and empties the
// transfer stage. A stalled receiver holds the output register; the sequencer
// then waits on the transfer stage while bytes remain, keeping o_in_stall high.
module char_lcd_write_sequencer #(
    parameter int LINE_LENGTH = lcdws_pkg::LINE_LENGTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lcdws_pkg::t_in_item  i_in_item,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcdws_pkg::t_out_item o_out_item
);

    localparam int PosW = $clog2(LINE_LENGTH + 2);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_JUMP  = 6'b000010,
        S_SEND  = 6'b000100,
        S_INIT  = 6'b001000,
        S_DIGIT = 6'b010000,
        S_PUSHD = 6'b100000
    } t_state;

    t_state                r_state;
    logic                  r_mode;
    logic [PosW-1:0]       r_pos;
    logic                  r_rs;
    logic [7:0]            r_byte;
    logic [2:0]            r_step;
    logic [15:0]           r_rem;
    logic [2:0]            r_idx;
    logic [3:0]            r_digit;
    logic                  r_started;

    lcdws_pkg::t_byte_req  req;
    logic                  xfer_ready;
    logic                  accept;
    logic [PosW-1:0]       pos_w;
    logic [7:0]            goto_addr;
    logic                  sub_ge;
    logic [15:0]           sub_diff;
    logic [15:0]           pow_w;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid & (r_state == S_IDLE);
    assign pos_w      = i_in_item.first_of_string ? '0 : r_pos;
    assign pow_w      = lcdws_pkg::pow10(r_idx);

    always_comb begin
        if (i_in_item.row == 8'd0) begin
            goto_addr = i_in_item.column;
        end else if (i_in_item.row == 8'd1) begin
            goto_addr = i_in_item.column + lcdws_pkg::ROW2_ADDR;
        end else begin
            goto_addr = 8'd0;
        end
        goto_addr = goto_addr | lcdws_pkg::CMD_SETADDR;
    end

    lcdws_cmp_sub u_cmp_sub (
        .i_a    (r_rem),
        .i_b    (pow_w),
        .o_ge   (sub_ge),
        .o_diff (sub_diff)
    );

    always_comb begin
        req.valid = 1'b0;
        req.rs    = 1'b0;
        req.data  = 8'd0;
        req.split = r_mode;
        req.last  = 1'b0;
        unique case (r_state)
            S_JUMP: begin
                req.valid = 1'b1;
                req.data  = lcdws_pkg::CMD_ROW2;
            end
            S_SEND: begin
                req.valid = 1'b1;
                req.rs    = r_rs;
                req.data  = r_byte;
                req.last  = 1'b1;
            end
            S_INIT: begin
                req.valid = 1'b1;
                unique case (r_step)
                    3'd0, 3'd1: begin
                        req.data  = lcdws_pkg::NIB_FUNC4;
                        req.split = 1'b0;
                    end
                    3'd2: begin
                        req.data  = r_mode ? lcdws_pkg::NIB_LINES : lcdws_pkg::CMD_FUNC8;
                        req.split = 1'b0;
                    end
                    3'd3: begin
                        req.data = lcdws_pkg::CMD_DISPON;
                    end
                    default: begin
                        req.data = lcdws_pkg::CMD_CLEAR;
                        req.last = 1'b1;
                    end
                endcase
            end
            S_PUSHD: begin
                req.valid = 1'b1;
                req.rs    = 1'b1;
                req.data  = lcdws_pkg::ASCII_ZERO + {4'b0000, r_digit};
                req.last  = (r_idx == lcdws_pkg::LAST_DIGIT);
            end
            default: begin
                req.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b1;
            r_pos     <= '0;
            r_step    <= 3'd0;
            r_idx     <= 3'd0;
            r_digit   <= 4'd0;
            r_started <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        priority case (i_in_item.kind)
                            lcdws_pkg::KIND_CMD, lcdws_pkg::KIND_DATA,
                            lcdws_pkg::KIND_GOTO: begin
                                r_state <= S_SEND;
                            end
                            lcdws_pkg::KIND_STRING: begin
                                r_state <= (pos_w == PosW'(LINE_LENGTH)) ? S_JUMP : S_SEND;
                                if (pos_w < PosW'(LINE_LENGTH + 1)) begin
                                    r_pos <= pos_w + 1'b1;
                                end else begin
                                    r_pos <= pos_w;
                                end
                            end
                            lcdws_pkg::KIND_NUMBER: begin
                                r_state   <= S_DIGIT;
                                r_idx     <= 3'd0;
                                r_digit   <= 4'd0;
                                r_started <= 1'b0;
                            end
                            lcdws_pkg::KIND_INIT: begin
                                r_state <= S_INIT;
                                r_step  <= r_mode ? 3'd0 : 3'd2;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_JUMP: begin
                    if (xfer_ready) begin
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (xfer_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_INIT: begin
                    if (xfer_ready) begin
                        if (r_step == 3'd4) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= r_step + 3'd1;
                        end
                    end
                end
                S_DIGIT: begin
                    if (sub_ge) begin
                        r_digit <= r_digit + 4'd1;
                    end else if (r_digit != 4'd0 || r_started
                                 || r_idx == lcdws_pkg::LAST_DIGIT) begin
                        r_state <= S_PUSHD;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_PUSHD: begin
                    if (xfer_ready) begin
                        r_started <= 1'b1;
                        r_digit   <= 4'd0;
                        if (r_idx == lcdws_pkg::LAST_DIGIT) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_DIGIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rs  <= (i_in_item.kind != lcdws_pkg::KIND_CMD)
                     && (i_in_item.kind != lcdws_pkg::KIND_GOTO);
            r_rem <= i_in_item.value;
            if (i_in_item.kind == lcdws_pkg::KIND_GOTO) begin
                r_byte <= goto_addr;
            end else begin
                r_byte <= i_in_item.value[7:0];
            end
        end else if (r_state == S_DIGIT && sub_ge) begin
            r_rem <= sub_diff;
        end
    end

    lcdws_xfer u_xfer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_ready (xfer_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

// ===== test/char_lcd_write_sequencer_tb.sv =====
// Self-checking testbench for char_lcd_write_sequencer: a directed table followed by
// random request traffic in both bus modes; every transfer is checked against a table
// row or a transfer predictor. Depends on lcdws_pkg and char_lcd_write_sequencer.
module char_lcd_write_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_UNDEF6 = 3'd6;
    localparam logic [2:0] KIND_UNDEF7 = 3'd7;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int ITEM_TARGET   = 370;
    localparam int RAND_PHASES   = 4;
    localparam int N_DIRECTED    = 25;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic                       mode;
        logic                       typed;
        logic [2:0]                 n_typed;
        lcdws_pkg::t_out_item [3:0] want;
        lcdws_pkg::t_in_item        req;
    } t_dir_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    lcdws_pkg::t_in_item  i_in_item     = '0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic                 i_cfg_wr_data = 1'b0;
    logic                 i_out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    lcdws_pkg::t_out_item o_out_item;

    logic                 nibble_mode = 1'b1;
    logic [4:0]           str_pos     = '0;
    lcdws_pkg::t_out_item lcd_xfers_due [$];
    lcdws_pkg::t_out_item wanted;
    int                   fail_count  = 0;
    int                   stall_left  = 0;
    logic                 rx_burst    = 1'b0;
    logic                 tx_burst    = 1'b0;
    t_dir_row             dir_tab [N_DIRECTED];

    char_lcd_write_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic lcdws_pkg::t_in_item req(input logic [2:0] kind,
                                                input logic [15:0] value,
                                                input logic first, input logic [7:0] col,
                                                input logic [7:0] row);
        return '{kind: kind, value: value, first_of_string: first, column: col, row: row};
    endfunction

    function automatic lcdws_pkg::t_out_item xf(input logic rs, input logic [7:0] bus,
                                                input logic fin);
        return '{reg_select: rs, bus_value: bus, last: fin};
    endfunction

    function automatic t_dir_row mk(input logic mode, input logic typed, input logic [2:0] n,
                                    input lcdws_pkg::t_in_item it,
                                    input lcdws_pkg::t_out_item t0 = '0,
                                    input lcdws_pkg::t_out_item t1 = '0,
                                    input lcdws_pkg::t_out_item t2 = '0,
                                    input lcdws_pkg::t_out_item t3 = '0);
        return '{mode: mode, typed: typed, n_typed: n, want: {t3, t2, t1, t0}, req: it};
    endfunction

    function automatic void put_raw(ref lcdws_pkg::t_out_item xs [$], input logic rs,
                                    input logic [7:0] bus);
        xs.push_back(xf(rs, bus, 1'b0));
    endfunction

    function automatic void put_byte(ref lcdws_pkg::t_out_item xs [$], input logic rs,
                                     input logic [7:0] b);
        if (nibble_mode) begin
            put_raw(xs, rs, {4'h0, b[7:4]});
            put_raw(xs, rs, {4'h0, b[3:0]});
        end else begin
            put_raw(xs, rs, b);
        end
    endfunction

    function automatic void predict_xfers(input lcdws_pkg::t_in_item it,
                                          ref lcdws_pkg::t_out_item xs [$]);
        int unsigned v;
        logic [7:0]  dg [5];
        int          nd;
        logic [7:0]  addr;
        case (it.kind)
            lcdws_pkg::KIND_CMD: put_byte(xs, 1'b0, it.value[7:0]);
            lcdws_pkg::KIND_DATA: put_byte(xs, 1'b1, it.value[7:0]);
            lcdws_pkg::KIND_STRING: begin
                if (it.first_of_string)
                    str_pos = '0;
                if (str_pos == lcdws_pkg::LINE_LENGTH_DEF)
                    put_byte(xs, 1'b0, lcdws_pkg::CMD_ROW2);
                put_byte(xs, 1'b1, it.value[7:0]);
                if (str_pos < lcdws_pkg::LINE_LENGTH_DEF + 1)
                    str_pos = str_pos + 5'd1;
            end
            lcdws_pkg::KIND_GOTO: begin
                if (it.row == 8'd0)
                    addr = it.column;
                else if (it.row == 8'd1)
                    addr = it.column + lcdws_pkg::ROW2_ADDR;
                else
                    addr = 8'h00;
                put_byte(xs, 1'b0, addr | lcdws_pkg::CMD_SETADDR);
            end
            lcdws_pkg::KIND_NUMBER: begin
                v  = it.value;
                nd = 0;
                do begin
                    dg[nd] = 8'(v % 10);
                    v      = v / 10;
                    nd++;
                end while (v > 0 && nd < 5);
                for (int k = nd - 1; k >= 0; k--)
                    put_byte(xs, 1'b1, dg[k] + lcdws_pkg::ASCII_ZERO);
            end
            lcdws_pkg::KIND_INIT: begin
                if (nibble_mode) begin
                    put_raw(xs, 1'b0, lcdws_pkg::NIB_FUNC4);
                    put_raw(xs, 1'b0, lcdws_pkg::NIB_FUNC4);
                    put_raw(xs, 1'b0, lcdws_pkg::NIB_LINES);
                end else begin
                    put_byte(xs, 1'b0, lcdws_pkg::CMD_FUNC8);
                end
                put_byte(xs, 1'b0, lcdws_pkg::CMD_DISPON);
                put_byte(xs, 1'b0, lcdws_pkg::CMD_CLEAR);
            end
            default: ;
        endcase
        if (xs.size() > 0)
            xs[xs.size() - 1].last = 1'b1;
    endfunction

    task automatic send_req(input lcdws_pkg::t_in_item it, input logic typed,
                            input logic [2:0] n_typed,
                            input lcdws_pkg::t_out_item [3:0] want);
        int                   gap;
        lcdws_pkg::t_out_item xs [$];
        if ($urandom_range(0, 24) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_xfers(it, xs);
        if (typed) begin
            for (int k = 0; k < n_typed; k++)
                lcd_xfers_due.push_back(want[k]);
        end else begin
            foreach (xs[k])
                lcd_xfers_due.push_back(xs[k]);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (lcd_xfers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        nibble_mode = m;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lcd_xfers_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected transfer: rs=%0d bus=%02h last=%0d",
                             o_out_item.reg_select, o_out_item.bus_value, o_out_item.last);
            end else begin
                wanted = lcd_xfers_due.pop_front();
                if (wanted.reg_select !== o_out_item.reg_select ||
                    wanted.bus_value !== o_out_item.bus_value ||
                    wanted.last !== o_out_item.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"transfer mismatch: expected rs=%0d bus=%02h last=%0d,",
                                  " got rs=%0d bus=%02h last=%0d"},
                                 wanted.reg_select, wanted.bus_value, wanted.last,
                                 o_out_item.reg_select, o_out_item.bus_value,
                                 o_out_item.last);
                end
            end
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            stall_left = rx_burst ? 0 : $urandom_range(0, 5);
        end else if (i_out_stall && stall_left > 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left != 0);
    end

    initial begin
        int                  issued;
        int                  len;
        int                  pick;
        int                  d;
        int                  lim;
        logic                held;
        lcdws_pkg::t_in_item it;

        dir_tab = '{
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_CMD, 16'hFFFF, 1'b0, 8'h00, 8'h00),
               xf(1'b0, 8'h0F, 1'b0), xf(1'b0, 8'h0F, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_DATA, 16'h0000, 1'b1, 8'hFF, 8'hFF),
               xf(1'b1, 8'h00, 1'b0), xf(1'b1, 8'h00, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_DATA, 16'hA55A, 1'b0, 8'h00, 8'h00),
               xf(1'b1, 8'h05, 1'b0), xf(1'b1, 8'h0A, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_GOTO, 16'h0000, 1'b0, 8'h00, 8'h00),
               xf(1'b0, 8'h08, 1'b0), xf(1'b0, 8'h00, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_GOTO, 16'hFFFF, 1'b1, 8'hFF, 8'h01),
               xf(1'b0, 8'h0B, 1'b0), xf(1'b0, 8'h0F, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_GOTO, 16'h0000, 1'b0, 8'hFF, 8'h00),
               xf(1'b0, 8'h0F, 1'b0), xf(1'b0, 8'h0F, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_GOTO, 16'h0000, 1'b0, 8'h55, 8'hFF),
               xf(1'b0, 8'h08, 1'b0), xf(1'b0, 8'h00, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_GOTO, 16'h0000, 1'b0, 8'h7F, 8'h02),
               xf(1'b0, 8'h08, 1'b0), xf(1'b0, 8'h00, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_NUMBER, 16'd0, 1'b0, 8'h00, 8'h00),
               xf(1'b1, 8'h03, 1'b0), xf(1'b1, 8'h00, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_NUMBER, 16'd9, 1'b0, 8'h00, 8'h00),
               xf(1'b1, 8'h03, 1'b0), xf(1'b1, 8'h09, 1'b1)),
            mk(1'b1, 1'b0, 3'd0, req(lcdws_pkg::KIND_NUMBER, 16'hFFFF, 1'b1, 8'hFF, 8'hFF)),
            mk(1'b1, 1'b0, 3'd0, req(lcdws_pkg::KIND_NUMBER, 16'd10000, 1'b0, 8'h00, 8'h00)),
            mk(1'b1, 1'b0, 3'd0, req(lcdws_pkg::KIND_INIT, 16'h0000, 1'b0, 8'h00, 8'h00)),
            mk(1'b1, 1'b1, 3'd0, req(KIND_UNDEF6, 16'hFFFF, 1'b1, 8'hFF, 8'hFF)),
            mk(1'b1, 1'b1, 3'd0, req(KIND_UNDEF7, 16'h0000, 1'b0, 8'h00, 8'h00)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_STRING, 16'h0000, 1'b1, 8'h00, 8'h00),
               xf(1'b1, 8'h00, 1'b0), xf(1'b1, 8'h00, 1'b1)),
            mk(1'b1, 1'b1, 3'd2, req(lcdws_pkg::KIND_STRING, 16'h12FF, 1'b0, 8'h00, 8'h00),
               xf(1'b1, 8'h0F, 1'b0), xf(1'b1, 8'h0F, 1'b1)),
            mk(1'b1, 1'b0, 3'd0, req(lcdws_pkg::KIND_STRING, 16'h0041, 1'b1, 8'h00, 8'h00)),
            mk(1'b0, 1'b1, 3'd1, req(lcdws_pkg::KIND_CMD, 16'h1234, 1'b0, 8'h00, 8'h00),
               xf(1'b0, 8'h34, 1'b1)),
            mk(1'b0, 1'b1, 3'd1, req(lcdws_pkg::KIND_DATA, 16'hFFFF, 1'b0, 8'h00, 8'h00),
               xf(1'b1, 8'hFF, 1'b1)),
            mk(1'b0, 1'b1, 3'd1, req(lcdws_pkg::KIND_GOTO, 16'h0000, 1'b0, 8'h10, 8'h01),
               xf(1'b0, 8'hD0, 1'b1)),
            mk(1'b0, 1'b1, 3'd3, req(lcdws_pkg::KIND_INIT, 16'h0000, 1'b0, 8'h00, 8'h00),
               xf(1'b0, 8'h3C, 1'b0), xf(1'b0, 8'h0C, 1'b0), xf(1'b0, 8'h01, 1'b1)),
            mk(1'b0, 1'b1, 3'd1, req(lcdws_pkg::KIND_NUMBER, 16'd7, 1'b0, 8'h00, 8'h00),
               xf(1'b1, 8'h37, 1'b1)),
            mk(1'b0, 1'b0, 3'd0, req(lcdws_pkg::KIND_NUMBER, 16'hFFFF, 1'b0, 8'h00, 8'h00)),
            mk(1'b0, 1'b0, 3'd0, req(lcdws_pkg::KIND_STRING, 16'h007A, 1'b0, 8'h00, 8'h00))
        };

        issued = 0;
        held   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != nibble_mode)
                set_mode(dir_tab[i].mode);
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].n_typed, dir_tab[i].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_mode(ph[0] == 1'b0);
            while (issued < (ph + 1) * ITEM_TARGET / RAND_PHASES) begin
                pick = $urandom_range(0, 99);
                it   = req(lcdws_pkg::KIND_CMD, 16'($urandom), 1'($urandom_range(0, 1)),
                           8'($urandom),
                           ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 1)));
                if (pick < 35) begin
                    // Mostly well-formed strings, some long enough to pass the end of row one.
                    len = $urandom_range(1, 24);
                    for (int k = 0; k < len; k++) begin
                        it.kind            = lcdws_pkg::KIND_STRING;
                        it.value           = ($urandom_range(0, 9) == 0) ? 16'h0000
                                                                         : 16'($urandom);
                        it.first_of_string = (k == 0);
                        if ($urandom_range(0, 9) == 0)
                            it.first_of_string = 1'($urandom_range(0, 1));
                        send_req(it, 1'b0, 3'd0, '0);
                        issued++;
                    end
                end else begin
                    if (pick < 47) begin
                        it.kind = lcdws_pkg::KIND_CMD;
                    end else if (pick < 57) begin
                        it.kind = lcdws_pkg::KIND_DATA;
                    end else if (pick < 69) begin
                        it.kind = lcdws_pkg::KIND_GOTO;
                    end else if (pick < 84) begin
                        it.kind = lcdws_pkg::KIND_NUMBER;
                        case ($urandom_range(0, 5))
                            0: it.value = 16'd0;
                            1: it.value = 16'hFFFF;
                            default: begin
                                d   = $urandom_range(1, 5);
                                lim = (d == 5) ? 65535 : (10 ** d - 1);
                                it.value = 16'($urandom_range(0, lim));
                            end
                        endcase
                    end else if (pick < 90) begin
                        it.kind = lcdws_pkg::KIND_INIT;
                    end else if (pick < 94) begin
                        it.kind = ($urandom_range(0, 1) == 0) ? KIND_UNDEF6 : KIND_UNDEF7;
                    end else begin
                        it.kind = 3'($urandom_range(0, 5));
                        it.row  = 8'($urandom);
                    end
                    send_req(it, 1'b0, 3'd0, '0);
                    if (it.kind <= lcdws_pkg::KIND_INIT)
                        issued++;
                end
                if ((!held && issued >= 40) || $urandom_range(0, 59) == 0) begin
                    wait_drained();
                    held = 1'b1;
                end
            end
        end

        i_in_valid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && lcd_xfers_due.size() != 0; c++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fail_count += lcd_xfers_due.size();

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
